// ----- hdl/afd_pkg.sv -----
`timescale 1ns / 1ps

package afd_pkg;

	// Field widths
	localparam int ACC_W   = 16;               // one acceleration axis
	localparam int TIME_W  = 32;               // millisecond timestamp
	localparam int LVL_W   = 15;               // level registers
	localparam int WIN_W   = 16;               // impact window register
	localparam int K_W     = 12;               // tilt gain, Q8
	localparam int SQ_W    = 2 * ACC_W;        // one square, also sum of squares
	localparam int KP_W    = SQ_W + K_W;       // gain times a sum of squares
	localparam int Q8_SH   = 8;                // fraction bits of the tilt gain

	// Stream payload widths
	localparam int S_TDATA_W = 3 * ACC_W + TIME_W;
	localparam int M_TDATA_W = 8;

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FREE_FALL_LEVEL  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMPACT_LEVEL     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMPACT_WINDOW_MS = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_TAN_SQ_Q8   = 8'd3;

	// Register reset values
	localparam logic [LVL_W-1:0] FREE_FALL_LEVEL_RST  = 15'd1254;  // 4.9 m/s^2
	localparam logic [LVL_W-1:0] IMPACT_LEVEL_RST     = 15'd4762;  // 18.6 m/s^2
	localparam logic [WIN_W-1:0] IMPACT_WINDOW_MS_RST = 16'd1000;
	localparam logic [K_W-1:0]   TILT_TAN_SQ_Q8_RST   = 12'd364;   // tan^2(50 deg)

	// Compare outcomes handed to the decision stage
	typedef struct packed {
		logic free_fall;
		logic impact;
		logic tilt_ok;
	} cmp_t;

	// Decision for the current sample
	typedef struct packed {
		logic fall;
		logic armed;
	} res_t;

	// Magnitude of a two's complement axis value; -32768 maps to 32768
	function automatic logic [ACC_W-1:0] abs_acc(input logic [ACC_W-1:0] v);
		logic [ACC_W-1:0] r;
		r = v[ACC_W-1] ? ACC_W'(~v + 1'b1) : v;
		return r;
	endfunction

endpackage

// ----- hdl/accel_fall_detector_core.sv -----
`timescale 1ns / 1ps

// Accelerometer fall detector. Each input beat carries one x/y/z sample
// (signed, 1/256 m/s^2) and a millisecond timestamp; each produces exactly
// one output beat with fall_detected and the armed flag after that sample.
// All tests work on exact squares, so no square root or angle is formed:
// free fall is x^2+y^2+z^2 < L^2, impact is x^2+y^2+z^2 > I^2, and the
// tilt test is 256x^2 > k(y^2+z^2), or z < 0, or 256y^2 > k z^2.
// Flow: a sample is accepted only when the core is idle, so the core
// takes no new sample until the result of the last one is committed.
// The work runs on shift-add multiplier lanes: first the five 16x16
// squares (three axes and the two levels, run side by side), then the
// sum of squares, then the two tilt gain products, and last the
// compare and the commit into the output register.
// While a result beat waits on the output, the next sample is still
// accepted and worked; only its final commit waits for the output slot.
// Configuration writes are always ready and should be issued while idle.
module accel_fall_detector_core (
	input  logic                              clk,
	input  logic                              arst_n,

	// Sample stream; tdata from bit 0: accel_x, accel_y, accel_z, time_ms
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [afd_pkg::S_TDATA_W-1:0]     s_axis_tdata,

	// Result stream; tdata from bit 0: fall_detected, free_fall_armed, zeros
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [afd_pkg::M_TDATA_W-1:0]     m_axis_tdata,

	// Register write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [afd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [afd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int ACC_W  = afd_pkg::ACC_W;
	localparam int SQ_W   = afd_pkg::SQ_W;
	localparam int K_W    = afd_pkg::K_W;
	localparam int KP_W   = afd_pkg::KP_W;
	localparam int TIME_W = afd_pkg::TIME_W;
	localparam int LVL_W  = afd_pkg::LVL_W;
	localparam int WIN_W  = afd_pkg::WIN_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_SUM,
		ST_KM,
		ST_EVAL,
		ST_OUT
	} state_t;

	state_t st_q;

	// Configuration registers
	logic [LVL_W-1:0] ff_level_q;
	logic [LVL_W-1:0] imp_level_q;
	logic [WIN_W-1:0] window_q;
	logic [K_W-1:0]   tilt_k_q;

	// Per-sample operands
	logic [TIME_W-1:0] now_q;
	logic              z_neg_q;
	logic [SQ_W-1:0]   m2_q;
	afd_pkg::cmp_t     cmp_q;

	logic                                m_tvalid_q;
	logic [afd_pkg::M_TDATA_W-1:0]       m_tdata_q;

	logic s_acc;
	logic commit;
	logic ph2_start;

	logic [ACC_W-1:0] ax_abs;
	logic [ACC_W-1:0] ay_abs;
	logic [ACC_W-1:0] az_abs;

	logic            dn_x, dn_y, dn_z, dn_ff, dn_im, dn_ks, dn_kz;
	logic            sq_done, km_done;
	logic [SQ_W-1:0] x2, y2, z2, ff2, im2;
	logic [SQ_W-1:0] s_yz;
	logic [KP_W-1:0] k_s_yz, k_z2;
	logic [KP_W-1:0] x2_q8, y2_q8;
	afd_pkg::cmp_t   cmp_d;
	afd_pkg::res_t   res;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// Commit the decision once the output slot is free or being drained
	assign commit    = (st_q == ST_OUT) && (!m_tvalid_q || m_axis_tready);
	assign ph2_start = (st_q == ST_SUM);

	assign ax_abs = afd_pkg::abs_acc(s_axis_tdata[ACC_W-1:0]);
	assign ay_abs = afd_pkg::abs_acc(s_axis_tdata[2*ACC_W-1:ACC_W]);
	assign az_abs = afd_pkg::abs_acc(s_axis_tdata[3*ACC_W-1:2*ACC_W]);

	// Register writes; mask each value to its register width, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_level_q  <= afd_pkg::FREE_FALL_LEVEL_RST;
			imp_level_q <= afd_pkg::IMPACT_LEVEL_RST;
			window_q    <= afd_pkg::IMPACT_WINDOW_MS_RST;
			tilt_k_q    <= afd_pkg::TILT_TAN_SQ_Q8_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				afd_pkg::REG_FREE_FALL_LEVEL:  ff_level_q  <= cfg_data[LVL_W-1:0];
				afd_pkg::REG_IMPACT_LEVEL:     imp_level_q <= cfg_data[LVL_W-1:0];
				afd_pkg::REG_IMPACT_WINDOW_MS: window_q    <= cfg_data[WIN_W-1:0];
				afd_pkg::REG_TILT_TAN_SQ_Q8:   tilt_k_q    <= cfg_data[K_W-1:0];
				default: ;
			endcase
		end
	end

	// Phase one: five squares side by side
	afd_smul #(.A_W(ACC_W), .B_W(ACC_W)) u_sq_x (
		.clk(clk), .arst_n(arst_n), .start(s_acc),
		.a(ax_abs), .b(ax_abs), .done(dn_x), .prod(x2)
	);
	afd_smul #(.A_W(ACC_W), .B_W(ACC_W)) u_sq_y (
		.clk(clk), .arst_n(arst_n), .start(s_acc),
		.a(ay_abs), .b(ay_abs), .done(dn_y), .prod(y2)
	);
	afd_smul #(.A_W(ACC_W), .B_W(ACC_W)) u_sq_z (
		.clk(clk), .arst_n(arst_n), .start(s_acc),
		.a(az_abs), .b(az_abs), .done(dn_z), .prod(z2)
	);
	afd_smul #(.A_W(ACC_W), .B_W(ACC_W)) u_sq_ff (
		.clk(clk), .arst_n(arst_n), .start(s_acc),
		.a({1'b0, ff_level_q}), .b({1'b0, ff_level_q}), .done(dn_ff), .prod(ff2)
	);
	afd_smul #(.A_W(ACC_W), .B_W(ACC_W)) u_sq_im (
		.clk(clk), .arst_n(arst_n), .start(s_acc),
		.a({1'b0, imp_level_q}), .b({1'b0, imp_level_q}), .done(dn_im), .prod(im2)
	);

	assign sq_done = dn_x & dn_y & dn_z & dn_ff & dn_im;

	// Phase two: tilt gain times y^2+z^2 and times z^2
	assign s_yz = y2 + z2;

	afd_smul #(.A_W(SQ_W), .B_W(K_W)) u_k_syz (
		.clk(clk), .arst_n(arst_n), .start(ph2_start),
		.a(s_yz), .b(tilt_k_q), .done(dn_ks), .prod(k_s_yz)
	);
	afd_smul #(.A_W(SQ_W), .B_W(K_W)) u_k_z2 (
		.clk(clk), .arst_n(arst_n), .start(ph2_start),
		.a(z2), .b(tilt_k_q), .done(dn_kz), .prod(k_z2)
	);

	assign km_done = dn_ks & dn_kz;

	// Squares scaled by 256 to meet the Q8 gain
	assign x2_q8 = {{(KP_W - SQ_W - afd_pkg::Q8_SH){1'b0}}, x2, {afd_pkg::Q8_SH{1'b0}}};
	assign y2_q8 = {{(KP_W - SQ_W - afd_pkg::Q8_SH){1'b0}}, y2, {afd_pkg::Q8_SH{1'b0}}};

	assign cmp_d.free_fall = (m2_q < ff2);
	assign cmp_d.impact    = (m2_q > im2);
	assign cmp_d.tilt_ok   = (x2_q8 > k_s_yz) || z_neg_q || (y2_q8 > k_z2);

	// Hold sample payload: timestamp and z sign at accept, sums and compares later
	always_ff @(posedge clk) begin
		if (s_acc) begin
			now_q   <= s_axis_tdata[3*ACC_W+TIME_W-1:3*ACC_W];
			z_neg_q <= s_axis_tdata[3*ACC_W-1];
		end
		if (ph2_start) begin
			m2_q <= x2 + s_yz;
		end
		if (st_q == ST_EVAL) begin
			cmp_q <= cmp_d;
		end
	end

	afd_eval u_eval (
		.clk(clk),
		.arst_n(arst_n),
		.commit(commit),
		.cmp(cmp_q),
		.now(now_q),
		.window(window_q),
		.res(res)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (commit) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {{(afd_pkg::M_TDATA_W - 2){1'b0}}, res.armed, res.fall};
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: if (s_acc)   st_q <= ST_SQ;
				ST_SQ:   if (sq_done) st_q <= ST_SUM;
				ST_SUM:               st_q <= ST_KM;
				ST_KM:   if (km_done) st_q <= ST_EVAL;
				ST_EVAL:              st_q <= ST_OUT;
				ST_OUT:  if (commit)  st_q <= ST_IDLE;
				default:              st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	// Square lanes finish only while the sequencer waits on them
	a_sq_done_in_sq: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (st_q == ST_SQ))
		else $error("square lanes finished outside the square phase");

	// Gain lanes finish only while the sequencer waits on them
	a_km_done_in_km: assert property (@(posedge clk) disable iff (!arst_n)
		km_done |-> (st_q == ST_KM))
		else $error("gain lanes finished outside the gain phase");

	// A committed decision shows on the output next cycle
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_axis_tvalid)
		else $error("committed result not presented");

	// A fall leaves the detector armed
	a_fall_armed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tdata[0] || m_axis_tdata[1]))
		else $error("fall reported with detector disarmed");

	// No sample enters while the previous one is still being worked
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> (st_q == ST_SQ))
		else $error("sample accepted without entering the square phase");

endmodule

// ----- hdl/afd_smul.sv -----
`timescale 1ns / 1ps

// Shift-add multiplier lane: one multiplier bit per cycle, LSB first.
module afd_smul #(
	parameter int A_W = afd_pkg::ACC_W,
	parameter int B_W = afd_pkg::ACC_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] prod
);

	localparam int CNT_W = $clog2(B_W + 1);

	logic               run_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [A_W-1:0]     a_q;
	logic [A_W+B_W-1:0] prod_q;
	logic [A_W:0]       sum;

	// Add the multiplicand into the high half when the current bit is set
	assign sum = {1'b0, prod_q[A_W+B_W-1:B_W]} + (prod_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(B_W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{A_W{1'b0}}, b};
		end else if (run_q) begin
			prod_q <= {sum, prod_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

// ----- hdl/afd_eval.sv -----
`timescale 1ns / 1ps

// Arm / impact / timeout decision and the detector state.
module afd_eval (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        commit,
	input  afd_pkg::cmp_t               cmp,
	input  logic [afd_pkg::TIME_W-1:0]  now,
	input  logic [afd_pkg::WIN_W-1:0]   window,
	output afd_pkg::res_t               res
);

	logic                       armed_q;
	logic [afd_pkg::TIME_W-1:0] start_q;
	logic                       armed_d;
	logic [afd_pkg::TIME_W-1:0] start_d;
	logic [afd_pkg::TIME_W-1:0] elapsed;
	logic                       fall;

	// Wrapping difference since arming
	assign elapsed = now - start_q;

	always_comb begin
		fall    = 1'b0;
		armed_d = armed_q;
		start_d = start_q;
		if (!armed_q) begin
			if (cmp.free_fall) begin
				armed_d = 1'b1;
				start_d = now;
			end
		end else if (cmp.impact) begin
			if (cmp.tilt_ok) begin
				fall = 1'b1;
			end else begin
				armed_d = 1'b0;
			end
		end else if (elapsed > {{(afd_pkg::TIME_W - afd_pkg::WIN_W){1'b0}}, window}) begin
			armed_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			start_q <= '0;
		end else if (commit) begin
			armed_q <= armed_d;
			start_q <= start_d;
		end
	end

	assign res.fall  = fall;
	assign res.armed = armed_d;

endmodule

// ----- tb/accel_fall_detector_core_tb.sv -----
`timescale 1ns / 1ps

module accel_fall_detector_core_tb;

	localparam int ACC_W      = afd_pkg::ACC_W;
	localparam int TIME_W     = afd_pkg::TIME_W;
	localparam int LVL_W      = afd_pkg::LVL_W;
	localparam int WIN_W      = afd_pkg::WIN_W;
	localparam int K_W        = afd_pkg::K_W;
	localparam int Q8_SH      = afd_pkg::Q8_SH;
	localparam int S_TDATA_W  = afd_pkg::S_TDATA_W;
	localparam int M_TDATA_W  = afd_pkg::M_TDATA_W;
	localparam int CFG_IDX_W  = afd_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = afd_pkg::CFG_DATA_W;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 12;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 600000;  // several times the slowest legal run

	// Index past the register map; the core must drop this write
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// Tracks the detector state and configuration, predicts the result
	// of every accepted sample and checks result beats in order.
	class fall_scoreboard;
		logic [LVL_W-1:0]  ff_level;
		logic [LVL_W-1:0]  impact_level;
		logic [WIN_W-1:0]  window_ms;
		logic [K_W-1:0]    tilt_k;
		bit                armed;
		logic [TIME_W-1:0] ff_start;
		afd_pkg::res_t     expected_q[$];
		int                mismatches;
		int                results_seen;

		function new();
			ff_level     = afd_pkg::FREE_FALL_LEVEL_RST;
			impact_level = afd_pkg::IMPACT_LEVEL_RST;
			window_ms    = afd_pkg::IMPACT_WINDOW_MS_RST;
			tilt_k       = afd_pkg::TILT_TAN_SQ_Q8_RST;
			armed        = 1'b0;
			ff_start     = '0;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		task report(input string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			mismatches++;
		endtask

		function longint unsigned axis_sq(input logic [ACC_W-1:0] v);
			int s;
			longint unsigned mag;
			s = int'($signed(v));
			mag = (s < 0) ? longint'(-s) : longint'(s);
			return mag * mag;
		endfunction

		function bit tilted(input longint unsigned x2, y2, z2, input bit z_neg);
			longint unsigned k;
			k = longint'(tilt_k);
			if ((x2 << Q8_SH) > k * (y2 + z2))
				return 1'b1;
			if (z_neg)
				return 1'b1;
			return (y2 << Q8_SH) > k * z2;
		endfunction

		function void note_config(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				afd_pkg::REG_FREE_FALL_LEVEL:  ff_level     = data[LVL_W-1:0];
				afd_pkg::REG_IMPACT_LEVEL:     impact_level = data[LVL_W-1:0];
				afd_pkg::REG_IMPACT_WINDOW_MS: window_ms    = data[WIN_W-1:0];
				afd_pkg::REG_TILT_TAN_SQ_Q8:   tilt_k       = data[K_W-1:0];
				default: ;
			endcase
		endfunction

		// Advance the detector by one sample and queue the result it owes
		function void note_sample(input logic [ACC_W-1:0] ax, ay, az,
				input logic [TIME_W-1:0] now);
			longint unsigned x2, y2, z2, m2;
			logic [TIME_W-1:0] elapsed;
			afd_pkg::res_t r;
			x2 = axis_sq(ax);
			y2 = axis_sq(ay);
			z2 = axis_sq(az);
			m2 = x2 + y2 + z2;
			r.fall = 1'b0;
			if (!armed) begin
				if (m2 < longint'(ff_level) * longint'(ff_level)) begin
					armed = 1'b1;
					ff_start = now;
				end
			end else if (m2 > longint'(impact_level) * longint'(impact_level)) begin
				if (tilted(x2, y2, z2, az[ACC_W-1]))
					r.fall = 1'b1;
				else
					armed = 1'b0;
			end else begin
				elapsed = now - ff_start;
				if (elapsed > TIME_W'(window_ms))
					armed = 1'b0;
			end
			r.armed = armed;
			expected_q.push_back(r);
		endfunction

		task check_result(input logic [M_TDATA_W-1:0] beat);
			afd_pkg::res_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				report($sformatf("result beat %0d arrived with no sample pending",
					results_seen));
				return;
			end
			want = expected_q.pop_front();
			if (beat[0] !== want.fall)
				report($sformatf("result beat %0d fall_detected got %b expected %b",
					results_seen, beat[0], want.fall));
			if (beat[1] !== want.armed)
				report($sformatf("result beat %0d free_fall_armed got %b expected %b",
					results_seen, beat[1], want.armed));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [S_TDATA_W-1:0]   s_axis_tdata;   // accel_x, accel_y, accel_z, time_ms
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [M_TDATA_W-1:0]   m_axis_tdata;   // fall_detected, free_fall_armed, zeros
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	fall_scoreboard  sb;
	idle_mode_t      idle_mode = IDLE_NONE;
	logic [TIME_W-1:0] clock_ms;
	int              cycle_count = 0;

	accel_fall_detector_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Hard stop: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("accel_fall_detector_core test failed");
			$finish;
		end
	end

	function automatic int gap_pct();
		case (idle_mode)
			IDLE_SENDER: return 46;
			IDLE_BOTH:   return 19;
			default:     return 0;
		endcase
	endfunction

	function automatic int stall_pct();
		case (idle_mode)
			IDLE_RECEIVER: return 46;
			IDLE_BOTH:     return 19;
			default:       return 0;
		endcase
	endfunction

	// Result side: check every beat taken, then pick the ready for the next edge
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct());
	end

	// Apply a random sign to an axis magnitude
	function automatic logic [ACC_W-1:0] signed_axis(input int unsigned mag);
		if ($urandom_range(0, 1))
			return ACC_W'(-int'(mag));
		return ACC_W'(mag);
	endfunction

	// Present one sample, hold it until taken, then tell the scoreboard.
	// Valid stays high between back-to-back samples; drop it only for a gap.
	task automatic send_sample(input logic [ACC_W-1:0] ax, ay, az,
			input logic [TIME_W-1:0] now);
		while ($urandom_range(0, 99) < gap_pct()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {now, az, ay, ax};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_sample(ax, ay, az, now);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.note_config(idx, data);
	endtask

	// Write all four registers back to back, then release the channel
	task automatic program_regs(input logic [CFG_DATA_W-1:0] ff, im, win, k);
		write_reg(afd_pkg::REG_FREE_FALL_LEVEL, ff);
		write_reg(afd_pkg::REG_IMPACT_LEVEL, im);
		write_reg(afd_pkg::REG_IMPACT_WINDOW_MS, win);
		write_reg(afd_pkg::REG_TILT_TAN_SQ_Q8, k);
		cfg_valid <= 1'b0;
	endtask

	// Random register set with junk above the width of the level and gain registers
	task automatic program_random_regs();
		program_regs({1'($urandom_range(0, 1)), 15'($urandom_range(300, 4000))},
			{1'($urandom_range(0, 1)), 15'($urandom_range(3000, 14000))},
			16'($urandom_range(0, 3000)),
			16'($urandom));
	endtask

	// Wait for the core to hand back every result it owes
	task automatic drain();
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed fall sequences: arm on a quiet sample, then either
	// an impact with random orientation or idle samples that may time out.
	// A tenth of the traffic is raw noise with jumps in the timestamp.
	task automatic random_item();
		logic [ACC_W-1:0] ax, ay, az;
		longint unsigned  m2;
		int               pick;
		int unsigned      b;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			ax = ACC_W'($urandom);
			ay = ACC_W'($urandom);
			az = ACC_W'($urandom);
			if ($urandom_range(0, 3) == 0)
				clock_ms = $urandom;
			else
				clock_ms += $urandom_range(0, 100);
		end else if (!sb.armed) begin
			// quiet sample: each axis at most half the level keeps |a| below it
			b = (pick < 75) ? sb.ff_level / 2 : sb.impact_level / 2;
			ax = signed_axis($urandom_range(0, b));
			ay = signed_axis($urandom_range(0, b));
			az = signed_axis($urandom_range(0, b));
			clock_ms += $urandom_range(0, 20);
		end else begin
			if (pick < 55) begin
				case ($urandom_range(0, 2))
					0: begin
						ax = ACC_W'($urandom);
						ay = ACC_W'($urandom);
						az = ACC_W'($urandom);
					end
					1: begin  // upright landing, tilt likely to fail
						ax = signed_axis($urandom_range(0, 6000));
						ay = signed_axis($urandom_range(0, 6000));
						az = ACC_W'($urandom_range(20000, 32767));
					end
					default: begin  // on the side
						ax = signed_axis($urandom_range(0, 32767));
						ay = signed_axis($urandom_range(10000, 32767));
						az = signed_axis($urandom_range(0, 20000));
					end
				endcase
				m2 = sb.axis_sq(ax) + sb.axis_sq(ay) + sb.axis_sq(az);
				if (m2 <= longint'(sb.impact_level) * longint'(sb.impact_level))
					ax = 16'h8000;
			end else begin
				b = sb.impact_level / 2;
				ax = signed_axis($urandom_range(0, b));
				ay = signed_axis($urandom_range(0, b));
				az = signed_axis($urandom_range(0, b));
			end
			// hit the window edge exactly now and then
			case ($urandom_range(0, 7))
				0: clock_ms = sb.ff_start + TIME_W'(sb.window_ms);
				1: clock_ms = sb.ff_start + TIME_W'(sb.window_ms) + 1;
				default: clock_ms += $urandom_range(0, sb.window_ms / 3 + 2);
			endcase
		end
		send_sample(ax, ay, az, clock_ms);
	endtask

	task automatic run_phase(input idle_mode_t mode, input int count);
		idle_mode = mode;
		clock_ms = $urandom;
		repeat (count)
			random_item();
		s_axis_tvalid <= 1'b0;
		drain();
	endtask

	initial begin
		sb = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed samples at reset settings: level edges, every tilt branch,
		// window edge and timestamp wrap
		send_sample(16'd0, 16'd0, 16'd2511, 32'd100);          // resting, stays idle
		send_sample(16'd1254, 16'd0, 16'd0, 32'd150);          // exactly free-fall level
		send_sample(16'd0, 16'd0, 16'd0, 32'd200);             // arms
		send_sample(16'd0, 16'h8000, 16'd0, 32'd210);          // impact, y branch
		send_sample(16'd4762, 16'd0, 16'd0, 32'd1200);         // exactly impact level, window edge
		send_sample(16'd100, 16'd100, 16'd100, 32'd1201);      // one past window, disarms
		send_sample(-16'sd1253, 16'd0, 16'd0, 32'hFFFF_FFF0);  // arms near wrap
		send_sample(16'd0, 16'd0, 16'd32767, 32'h0000_0100);   // upright impact, disarms
		send_sample(16'd0, 16'd0, 16'hFFFF, 32'h0000_0200);    // arms
		send_sample(16'd20000, 16'd0, 16'd10000, 32'h0000_0210); // x branch
		send_sample(16'd0, 16'd5000, 16'd20000, 32'h0000_0220);  // tilt fails
		send_sample(16'd1, 16'd1, 16'd1, 32'hFFFF_FFFF);        // arms at wrap point
		send_sample(16'h8000, 16'h8000, 16'h8000, 32'h0);       // z negative branch
		send_sample(16'd32767, 16'd32767, 16'd32767, 32'd999);  // all max, tilt fails
		send_sample(16'd0, 16'd0, 16'd0, 32'h7FFF_FFFF);
		send_sample(16'd0, 16'd0, 16'd0, 32'h7FFF_FFFF + 32'd1000);
		send_sample(16'd0, 16'd0, 16'd0, 32'h7FFF_FFFF + 32'd1001); // times out
		send_sample(16'd0, 16'd0, 16'd0, 32'h7FFF_FFFF + 32'd1001); // rearms
		send_sample(16'd0, 16'd20000, -16'sd5, 32'h8000_0400);  // z sign and y branch both pass
		send_sample(16'd0, 16'd20000, 16'd5, 32'h8000_0401);    // y branch
		send_sample(16'd0, 16'd100, 16'd5000, 32'h8000_0402);   // tilt fails
		send_sample(16'h5555, 16'hAAAA, 16'h5555, 32'hAAAA_5555);
		send_sample(16'hAAAA, 16'h5555, 16'hAAAA, 32'h5555_AAAA);
		s_axis_tvalid <= 1'b0;
		drain();

		run_phase(IDLE_NONE, 240);

		// Extremes: widest free-fall level, anything nonzero is an impact,
		// zero window, widest tilt gain; all-ones data checks masking
		program_regs(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
		run_phase(IDLE_SENDER, 180);

		// Opposite extremes: nothing arms, longest window, zero gain
		program_regs(16'h0000, 16'h7FFF, 16'hFFFF, 16'h0000);
		run_phase(IDLE_RECEIVER, 80);

		// Unmapped index must leave the settings alone
		write_reg(REG_UNMAPPED, 16'hFFFF);
		program_random_regs();
		run_phase(IDLE_BOTH, 260);

		program_regs(16'd2000, 16'd6000, 16'd50, 16'd364);
		run_phase(IDLE_SENDER, 200);

		program_random_regs();
		run_phase(IDLE_RECEIVER, 200);

		program_random_regs();
		run_phase(IDLE_BOTH, 190);

		// Let any stray beat show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("accel_fall_detector_core test passed");
		else
			$display("accel_fall_detector_core test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/afd_pkg.sv
hdl/afd_smul.sv
hdl/afd_eval.sv
hdl/accel_fall_detector_core.sv
tb/accel_fall_detector_core_tb.sv
